// File: hdl/swa_pkg.sv
// Package for the sliding window average block.
// Holds widths, the window length and the sequencer state type.
// No dependencies.
package swa_pkg;

    localparam int WINDOW   = 24;
    localparam int SAMPLE_W = 24;
    localparam int SLOT_W   = $clog2(WINDOW);
    localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int ITER_W   = $clog2(SUM_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_LOAD
    } t_state;

endpackage

// File: hdl/swa_if.sv
// Valid/ready channel interfaces for the sliding window average block.
// Depends on swa_pkg for payload widths.
interface swa_in_if;
    logic                           valid;
    logic                           ready;
    logic [swa_pkg::SAMPLE_W-1:0]   sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swa_out_if;
    logic                           valid;
    logic                           ready;
    logic [swa_pkg::SAMPLE_W-1:0]   average;
    logic                           window_full;

    modport source (output valid, output average, output window_full, input ready);
    modport sink   (input valid, input average, input window_full, output ready);
endinterface

// File: hdl/sliding_window_average.sv
// Sliding window average with warm-up: top level, ring, window sum and sequencer.
// Depends on swa_pkg, swa_if, swa_ram and swa_divider.
//
//  channel | dir | fields                       | per item
//  i_in    | in  | sample[23:0]                 | one sample
//  o_out   | out | average[23:0], window_full   | one result
//
// Each item goes through the read, divide and load states before the next ready;
// the bit-serial divider sets the pace, one quotient bit per cycle.
// Synchronous active-low reset clears sum, write slot, fill flag and valid;
// the ring has no reset value; its old data is used only after it has filled once.
// A stalled result holds in the output register; the block accepts the next item
// while it waits, and waits before loading only if the register is still full.
module sliding_window_average (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swa_in_if.sink      i_in,
    swa_out_if.source   o_out
);

    swa_pkg::t_state                   r_state;
    swa_pkg::t_state                   n_state;
    logic [swa_pkg::SAMPLE_W-1:0]      r_sample;
    logic [swa_pkg::SUM_W-1:0]         r_sum;
    logic [swa_pkg::SUM_W-1:0]         n_sum;
    logic [swa_pkg::SLOT_W-1:0]        r_slot;
    logic [swa_pkg::SLOT_W-1:0]        n_slot;
    logic                              r_filled;
    logic                              r_ovalid;
    logic [swa_pkg::SAMPLE_W-1:0]      r_avg;
    logic                              r_full;
    logic [swa_pkg::CNT_W-1:0]         w_count;
    logic [swa_pkg::SAMPLE_W-1:0]      w_old;
    logic [swa_pkg::SUM_W-1:0]         w_quo;
    logic                              w_div_done;
    logic                              w_accept;
    logic                              w_ready;
    logic                              w_update;
    logic                              w_load;
    logic                              w_wrap;

    assign w_accept = i_in.valid && w_ready;
    assign w_wrap   = r_slot == swa_pkg::SLOT_W'(swa_pkg::WINDOW - 1);

    swa_ram #(
        .WIDTH (swa_pkg::SAMPLE_W),
        .DEPTH (swa_pkg::WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_update),
        .i_waddr (r_slot),
        .i_wdata (r_sample),
        .i_re    (w_accept),
        .i_raddr (r_slot),
        .o_rdata (w_old)
    );

    always_comb begin
        if (r_filled) begin
            n_sum   = r_sum - swa_pkg::SUM_W'(w_old) + swa_pkg::SUM_W'(r_sample);
            w_count = swa_pkg::CNT_W'(swa_pkg::WINDOW);
        end else begin
            n_sum   = r_sum + swa_pkg::SUM_W'(r_sample);
            w_count = swa_pkg::CNT_W'(r_slot) + 1'b1;
        end
        n_slot = w_wrap ? '0 : r_slot + 1'b1;
    end

    swa_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_update),
        .i_dividend (n_sum),
        .i_divisor  (w_count),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            swa_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = swa_pkg::ST_READ;
                end
            end
            swa_pkg::ST_READ: begin
                n_state = swa_pkg::ST_DIV;
            end
            swa_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = swa_pkg::ST_LOAD;
                end
            end
            swa_pkg::ST_LOAD: begin
                if (!r_ovalid || o_out.ready) begin
                    n_state = swa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = swa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_ready  = 1'b0;
        w_update = 1'b0;
        w_load   = 1'b0;
        unique case (r_state)
            swa_pkg::ST_IDLE: w_ready  = 1'b1;
            swa_pkg::ST_READ: w_update = 1'b1;
            swa_pkg::ST_DIV:  w_load   = 1'b0;
            swa_pkg::ST_LOAD: w_load   = !r_ovalid || o_out.ready;
            default:          w_ready  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= swa_pkg::ST_IDLE;
            r_sum    <= '0;
            r_slot   <= '0;
            r_filled <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_update) begin
                r_sum  <= n_sum;
                r_slot <= n_slot;
                if (w_wrap) begin
                    r_filled <= 1'b1;
                end
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_in.sample;
        end
        if (w_load) begin
            r_avg  <= w_quo[swa_pkg::SAMPLE_W-1:0];
            r_full <= r_filled;
        end
    end

    assign i_in.ready        = w_ready;
    assign o_out.valid       = r_ovalid;
    assign o_out.average     = r_avg;
    assign o_out.window_full = r_full;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_in.ready)
        else $error("input accepted again while an item is in progress");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == swa_pkg::ST_DIV)
        else $error("divider finished outside the divide state");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= swa_pkg::SLOT_W'(swa_pkg::WINDOW - 1))
        else $error("write slot beyond the window");

    a_filled_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_filled) && $past(i_rst_n) |-> r_filled)
        else $error("fill flag cleared without reset");

endmodule

// File: hdl/swa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/swa_divider.sv
// Bit-serial restoring divider: window sum by sample count, one quotient bit a cycle.
// Depends on swa_pkg for widths.
module swa_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [swa_pkg::SUM_W-1:0]   i_dividend,
    input  logic [swa_pkg::CNT_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [swa_pkg::SUM_W-1:0]   o_quotient
);

    logic                          r_busy;
    logic                          r_done;
    logic [swa_pkg::ITER_W-1:0]    r_iter;
    logic [swa_pkg::SUM_W-1:0]     r_quo;
    logic [swa_pkg::CNT_W-1:0]     r_rem;
    logic [swa_pkg::CNT_W-1:0]     r_div;
    logic [swa_pkg::CNT_W:0]       w_trial;
    logic                          w_fit;
    logic [swa_pkg::CNT_W:0]       w_diff;

    assign w_trial = {r_rem, r_quo[swa_pkg::SUM_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
            end else if (r_busy) begin
                r_iter <= r_iter + 1'b1;
                if (r_iter == swa_pkg::ITER_W'(swa_pkg::SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[swa_pkg::SUM_W-2:0], w_fit};
            r_rem <= w_fit ? w_diff[swa_pkg::CNT_W-1:0] : w_trial[swa_pkg::CNT_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: test/tb_sliding_window_average.sv
`timescale 1ns / 100ps
// Testbench for sliding_window_average: clocked driver and monitor over the valid/ready
// channels, with a local moving-average predictor. Depends on swa_pkg, swa_if and the RTL.
module tb_sliding_window_average;

    localparam int N_ITEMS     = 1750;
    localparam int STALL_LIMIT = 4000;
    localparam int IDLE_PCT    = 11;
    localparam int CALM_LO     = 700;
    localparam int CALM_HI     = 1000;

    typedef struct packed {
        logic [swa_pkg::SAMPLE_W-1:0] average;
        logic                         window_full;
    } t_avg_result;

    typedef struct packed {
        logic [swa_pkg::SAMPLE_W-1:0] sample;
        logic                         wait_drain;
    } t_sample_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    swa_in_if  in_ch ();
    swa_out_if out_ch ();

    sliding_window_average dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_sample_item pending_samples[$];
    t_avg_result  expected_averages[$];

    logic [swa_pkg::SAMPLE_W-1:0] ring [swa_pkg::WINDOW];
    logic [swa_pkg::SUM_W-1:0]    run_sum = '0;
    logic [swa_pkg::SLOT_W-1:0]   next_slot = '0;
    logic                         ring_filled = 1'b0;

    logic in_accepted = 1'b0;
    int   samples_taken = 0;
    int   results_seen = 0;
    int   stall_cycles = 0;
    int   error_count = 0;

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.sample = '0;
        out_ch.ready = 1'b0;
    end

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_avg_result predict_average(input logic [swa_pkg::SAMPLE_W-1:0] s);
        logic [swa_pkg::SUM_W-1:0] divisor;
        logic [swa_pkg::SUM_W-1:0] quotient;
        t_avg_result               r;
        if (ring_filled) begin
            run_sum = run_sum - swa_pkg::SUM_W'(ring[next_slot]);
        end
        run_sum = run_sum + swa_pkg::SUM_W'(s);
        ring[next_slot] = s;
        divisor = ring_filled ? swa_pkg::SUM_W'(swa_pkg::WINDOW)
                              : swa_pkg::SUM_W'(next_slot) + 1'b1;
        quotient = run_sum / divisor;
        if (next_slot == swa_pkg::SLOT_W'(swa_pkg::WINDOW - 1)) begin
            next_slot = '0;
            ring_filled = 1'b1;
        end else begin
            next_slot = next_slot + 1'b1;
        end
        r.average = quotient[swa_pkg::SAMPLE_W-1:0];
        r.window_full = ring_filled;
        return r;
    endfunction

    function automatic void queue_sample(input logic [swa_pkg::SAMPLE_W-1:0] s,
                                         input logic drain);
        t_sample_item it;
        it.sample = s;
        it.wait_drain = drain;
        pending_samples.push_back(it);
    endfunction

    // driver: hold the item until accepted, then advance
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_accepted) begin
            if (pending_samples.size() == 0) begin
                in_ch.valid <= 1'b0;
            end else if (pending_samples[0].wait_drain && expected_averages.size() != 0) begin
                in_ch.valid <= 1'b0;
            end else if (!(samples_taken >= CALM_LO && samples_taken < CALM_HI) &&
                         $urandom_range(0, 99) < IDLE_PCT) begin
                in_ch.valid <= 1'b0;
            end else begin
                in_ch.valid  <= 1'b1;
                in_ch.sample <= pending_samples[0].sample;
                pending_samples.delete(0);
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= (results_seen >= CALM_LO && results_seen < CALM_HI) ||
                            ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // monitor: predict on input accept, compare on output accept
    always @(posedge i_clk) begin
        t_avg_result want;
        logic        in_fire;
        logic        out_fire;
        in_fire  = i_rst_n && in_ch.valid && in_ch.ready;
        out_fire = i_rst_n && out_ch.valid && out_ch.ready;
        in_accepted <= in_fire;
        if (in_fire) begin
            expected_averages.push_back(predict_average(in_ch.sample));
            samples_taken++;
        end
        if (out_fire) begin
            results_seen++;
            if (expected_averages.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual average %h full %b",
                         $time, out_ch.average, out_ch.window_full);
                error_count++;
            end else begin
                want = expected_averages.pop_front();
                if (out_ch.average !== want.average) begin
                    $display("%0t: average mismatch, expected %h, actual %h",
                             $time, want.average, out_ch.average);
                    error_count++;
                end
                if (out_ch.window_full !== want.window_full) begin
                    $display("%0t: window_full mismatch, expected %b, actual %b",
                             $time, want.window_full, out_ch.window_full);
                    error_count++;
                end
            end
        end
        if (i_rst_n) begin
            if (in_fire || out_fire) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb_sliding_window_average: done, errors");
                $finish;
            end
        end
    end

    initial begin
        logic [swa_pkg::SAMPLE_W-1:0] directed [25];
        int                           n;
        int                           mode;
        int                           run;
        logic [swa_pkg::SAMPLE_W-1:0] s;
        directed = '{24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000001, 24'h800000,
                     24'h7FFFFF, 24'h000100, 24'h0000FF, 24'hFFFFFF, 24'hFFFFFF,
                     24'hFFFFFF, 24'hFFFFFF, 24'h555555, 24'hAAAAAA, 24'h000000,
                     24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                     24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h000000};
        foreach (directed[i]) begin
            queue_sample(directed[i], 1'b0);
        end
        n = 0;
        while (n < N_ITEMS) begin
            mode = $urandom_range(0, 5);
            run  = $urandom_range(1, 60);
            for (int k = 0; k < run; k++) begin
                case (mode) inside
                    0, 1:    s = swa_pkg::SAMPLE_W'($urandom);
                    2:       s = '1;
                    3:       s = '0;
                    4:       s = swa_pkg::SAMPLE_W'($urandom_range(0, 255));
                    default: s = swa_pkg::SAMPLE_W'(24'hFFFFFF - $urandom_range(0, 4095));
                endcase
                queue_sample(s, (n == 0) || ($urandom_range(0, 199) == 0));
                n++;
            end
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_samples.size() != 0 || in_ch.valid) @(posedge i_clk);
        while (expected_averages.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_sliding_window_average: done, clean");
        end else begin
            $display("tb_sliding_window_average: done, errors");
        end
        $finish;
    end

endmodule
